// ----- src/tah_pkg.sv -----
// Shared types and constants for the traffic activity hysteresis block.
// No dependencies; used by tah_engine and traffic_activity_hysteresis_fsm.
package tah_pkg;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ARMING  = 2'd1,
        PH_ACTIVE  = 2'd2,
        PH_COOLING = 2'd3
    } t_phase;

    localparam int CfgIndexBits = 3;
    localparam int CfgDataBits  = 64;
    localparam int CountBits    = 64;
    localparam int DelayBits    = 32;
    localparam int TotalBits    = 32;
    localparam int OutBits      = 40;

    localparam logic [CfgIndexBits-1:0] REG_ENABLE_DELAY   = 3'd0;
    localparam logic [CfgIndexBits-1:0] REG_DISABLE_DELAY  = 3'd1;
    localparam logic [CfgIndexBits-1:0] REG_POLL_INTERVAL  = 3'd2;
    localparam logic [CfgIndexBits-1:0] REG_ARM_GRACE      = 3'd3;
    localparam logic [CfgIndexBits-1:0] REG_ACTIVE_GRACE   = 3'd4;
    localparam logic [CfgIndexBits-1:0] REG_BASELINE_COUNT = 3'd5;

    localparam logic [DelayBits-1:0] RST_ENABLE_DELAY  = 32'd2000000;
    localparam logic [DelayBits-1:0] RST_DISABLE_DELAY = 32'd30000000;
    localparam logic [DelayBits-1:0] RST_POLL_INTERVAL = 32'd1000000;
    localparam logic [DelayBits-1:0] RST_ARM_GRACE     = 32'd5000000;
    localparam logic [DelayBits-1:0] RST_ACTIVE_GRACE  = 32'd5000000;

    typedef struct packed {
        logic                    en;
        logic [CfgIndexBits-1:0] index;
        logic [CfgDataBits-1:0]  data;
    } t_cfg_write;

    typedef struct packed {
        logic [TotalBits-1:0] activation_total;
        logic                 traffic_seen;
        logic                 sampled;
        t_phase               phase;
    } t_result;

endpackage

// ----- src/traffic_activity_hysteresis_fsm.sv -----
// Top level of the traffic activity hysteresis detector.
// Depends on tah_pkg and tah_engine.
//
// Usage:
// Each poll enters on the s_axis channel as one transaction. The tdata word carries the
// timestamp in microseconds and the packet counter reading; tuser carries the flag that
// says whether the counter read succeeded. Every poll produces exactly one result
// transaction on the m_axis channel with the phase, the sampled flag, the latest
// traffic flag and the wrapping activation count.
// A poll is captured in an input register and evaluated when it moves on into the
// result register, which waits while the receiver stalls; the result is then offered.
// Throughput is one poll per cycle while the receiver takes each result; the engine
// updates its tracking state as each poll is evaluated.
// When the receiver stalls, the waiting result holds and one more poll is taken into
// the input register; after that s_axis tready stays low until the result leaves.
// The cfg channel is always ready and writes one register per transaction. Use it only
// while no poll is in flight; the block does not check it. Reset restores the register
// defaults, sets phase idle, clears all timestamps and empties both pipeline registers.
module traffic_activity_hysteresis_fsm #(
    parameter int TIME_BITS = 48,
    localparam int InBits = ((TIME_BITS + tah_pkg::CountBits + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // Fields from bit 0: time_now, packet_count, zero padding.
    input  logic [InBits-1:0]                 i_s_axis_tdata,
    // Fields from bit 0: count_valid.
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // Fields from bit 0: phase, sampled, traffic_seen, activation_total, zero padding.
    output logic [tah_pkg::OutBits-1:0]       o_m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tah_pkg::CfgIndexBits-1:0]  i_cfg_index,
    input  logic [tah_pkg::CfgDataBits-1:0]   i_cfg_data
);
    import tah_pkg::*;

    logic                 r_in_valid;
    logic [TIME_BITS-1:0] r_in_time;
    logic [CountBits-1:0] r_in_count;
    logic                 r_in_count_valid;
    logic                 r_out_valid;
    logic [OutBits-1:0]   r_out_data;
    logic                 w_advance;
    logic                 w_in_take;
    t_cfg_write           w_cfg;
    t_result              w_result;

    assign o_cfg_ready = 1'b1;
    assign w_cfg.en    = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_time        <= i_s_axis_tdata[TIME_BITS-1:0];
            r_in_count       <= i_s_axis_tdata[TIME_BITS +: CountBits];
            r_in_count_valid <= i_s_axis_tuser;
        end
    end

    tah_engine #(
        .TIME_BITS(TIME_BITS)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_step         (w_advance),
        .i_time_now     (r_in_time),
        .i_packet_count (r_in_count),
        .i_count_valid  (r_in_count_valid),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= OutBits'(w_result);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_empty_input_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_s_axis_tready)
        else $error("Input register is empty but the poll channel is not ready.");

    a_advance_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("An evaluated poll did not produce a pending result.");

    a_unsampled_keeps_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && !w_result.sampled && r_out_valid |->
        w_result.activation_total == r_out_data[4 +: TotalBits])
        else $error("The activation count moved on a poll that was not sampled.");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("Pipeline registers are not empty after reset.");

endmodule

// ----- src/tah_engine.sv -----
// Configuration registers, tracking state and phase machine of the detector.
// Depends on tah_pkg; instantiated by traffic_activity_hysteresis_fsm.
module tah_engine #(
    parameter int TIME_BITS = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tah_pkg::t_cfg_write            i_cfg,
    input  logic                           i_step,
    input  logic [TIME_BITS-1:0]           i_time_now,
    input  logic [tah_pkg::CountBits-1:0]  i_packet_count,
    input  logic                           i_count_valid,
    output tah_pkg::t_result               o_result
);
    import tah_pkg::*;

    logic [DelayBits-1:0] r_enable_delay;
    logic [DelayBits-1:0] r_disable_delay;
    logic [DelayBits-1:0] r_poll_interval;
    logic [DelayBits-1:0] r_arm_grace;
    logic [DelayBits-1:0] r_active_grace;

    t_phase               r_phase;
    t_phase               n_phase;
    logic [CountBits-1:0] r_prev_count;
    logic [TIME_BITS-1:0] r_last_sample;
    logic [TIME_BITS-1:0] r_last_traffic;
    logic [TIME_BITS-1:0] r_arm_start;
    logic [TIME_BITS-1:0] r_cool_start;
    logic [TotalBits-1:0] r_act_count;
    logic [TotalBits-1:0] n_act_count;
    logic                 r_traffic_flag;

    logic                 w_take;
    logic                 w_sample;
    logic                 w_traffic;
    logic [TIME_BITS-1:0] w_last_traffic;
    logic [TIME_BITS-1:0] w_d_sample;
    logic [TIME_BITS-1:0] w_d_traffic;
    logic [TIME_BITS-1:0] w_d_arm;
    logic [TIME_BITS-1:0] w_d_cool;
    logic                 w_arm_gone;
    logic                 w_active_gone;
    logic                 w_enable_done;
    logic                 w_disable_done;

    assign w_traffic      = i_packet_count > r_prev_count;
    assign w_last_traffic = w_traffic ? i_time_now : r_last_traffic;

    assign w_d_sample  = i_time_now - r_last_sample;
    assign w_d_traffic = i_time_now - w_last_traffic;
    assign w_d_arm     = i_time_now - r_arm_start;
    assign w_d_cool    = i_time_now - r_cool_start;

    assign w_take = (r_last_sample == '0) ||
                    ((i_time_now >= r_last_sample) &&
                     (w_d_sample >= TIME_BITS'(r_poll_interval)));
    assign w_sample = w_take && i_count_valid;

    assign w_arm_gone    = (w_last_traffic != '0) && (i_time_now >= w_last_traffic) &&
                           (w_d_traffic > TIME_BITS'(r_arm_grace));
    assign w_active_gone = (w_last_traffic != '0) && (i_time_now >= w_last_traffic) &&
                           (w_d_traffic > TIME_BITS'(r_active_grace));
    assign w_enable_done  = (i_time_now >= r_arm_start) &&
                            (w_d_arm >= TIME_BITS'(r_enable_delay));
    assign w_disable_done = (i_time_now >= r_cool_start) &&
                            (w_d_cool >= TIME_BITS'(r_disable_delay));

    always_comb begin
        n_phase     = r_phase;
        n_act_count = r_act_count;
        unique case (r_phase)
            PH_IDLE: begin
                if (w_traffic) begin
                    n_phase = PH_ARMING;
                end
            end
            PH_ARMING: begin
                if (w_arm_gone) begin
                    n_phase = PH_IDLE;
                end else if (w_enable_done) begin
                    n_phase     = PH_ACTIVE;
                    n_act_count = r_act_count + 1'b1;
                end
            end
            PH_ACTIVE: begin
                if (w_active_gone) begin
                    n_phase = PH_COOLING;
                end
            end
            PH_COOLING: begin
                if (w_traffic) begin
                    n_phase = PH_ACTIVE;
                end else if (w_disable_done) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_delay  <= RST_ENABLE_DELAY;
            r_disable_delay <= RST_DISABLE_DELAY;
            r_poll_interval <= RST_POLL_INTERVAL;
            r_arm_grace     <= RST_ARM_GRACE;
            r_active_grace  <= RST_ACTIVE_GRACE;
        end else if (i_cfg.en) begin
            case (i_cfg.index)
                REG_ENABLE_DELAY:  r_enable_delay  <= i_cfg.data[DelayBits-1:0];
                REG_DISABLE_DELAY: r_disable_delay <= i_cfg.data[DelayBits-1:0];
                REG_POLL_INTERVAL: r_poll_interval <= i_cfg.data[DelayBits-1:0];
                REG_ARM_GRACE:     r_arm_grace     <= i_cfg.data[DelayBits-1:0];
                REG_ACTIVE_GRACE:  r_active_grace  <= i_cfg.data[DelayBits-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_prev_count   <= '0;
            r_last_sample  <= '0;
            r_last_traffic <= '0;
            r_arm_start    <= '0;
            r_cool_start   <= '0;
            r_act_count    <= '0;
            r_traffic_flag <= 1'b0;
        end else begin
            if (i_cfg.en && (i_cfg.index == REG_BASELINE_COUNT)) begin
                r_prev_count <= i_cfg.data;
            end else if (i_step && w_sample) begin
                r_prev_count <= i_packet_count;
            end
            if (i_step && w_take) begin
                r_last_sample <= i_time_now;
            end
            if (i_step && w_sample) begin
                r_phase        <= n_phase;
                r_act_count    <= n_act_count;
                r_traffic_flag <= w_traffic;
                r_last_traffic <= w_last_traffic;
                if ((r_phase == PH_IDLE) && w_traffic) begin
                    r_arm_start <= i_time_now;
                end
                if ((r_phase == PH_ACTIVE) && w_active_gone) begin
                    r_cool_start <= i_time_now;
                end
            end
        end
    end

    always_comb begin
        o_result.phase            = w_sample ? n_phase : r_phase;
        o_result.sampled          = w_sample;
        o_result.traffic_seen     = w_sample ? w_traffic : r_traffic_flag;
        o_result.activation_total = w_sample ? n_act_count : r_act_count;
    end

endmodule
